// ===== src/rmj_pkg.sv =====
// Shared constants and helpers for the radar measurement Jacobian unit.
// No dependencies.
`timescale 1ns / 1ps

package rmj_pkg;

  localparam int WORD_W = 32;
  localparam int MAG_W  = 33;
  // magnitude cap: anything at or above this saturates either way
  localparam logic [MAG_W-1:0] MAG_CAP = 33'h1_0000_0000;

  // apply sign to a magnitude and saturate to a 32-bit two's complement word
  function automatic logic [WORD_W-1:0] sat32(input logic [MAG_W-1:0] mag, input logic neg);
    logic [WORD_W-1:0] res;
    if (neg) begin
      if (mag >= 33'h0_8000_0000) res = 32'h8000_0000;
      else res = (~mag[WORD_W-1:0]) + 32'd1;
    end else begin
      if (mag > 33'h0_7fff_ffff) res = 32'h7fff_ffff;
      else res = mag[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== src/rmj_delay.sv =====
// Enabled shift line that keeps side data aligned with the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps

module rmj_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int i = 1; i < D; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[D-1];

endmodule

// ===== src/rmj_sqrt.sv =====
// Pipelined 64-bit integer square root, one root bit per stage (32 stages).
// No dependencies.
`timescale 1ns / 1ps

module rmj_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);

  logic [63:0] rem [33];
  logic [31:0] rt  [33];

  assign rem[0] = x;
  assign rt[0]  = '0;

  for (genvar i = 0; i < 32; i++) begin : g_stage
    localparam int B = 31 - i;
    logic [64:0] term;
    // (r + 2^b)^2 - r^2
    assign term = (65'(rt[i]) << (B + 1)) + (65'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[i]} >= term) begin
          rem[i+1] <= rem[i] - term[63:0];
          rt[i+1]  <= rt[i] | (32'(1) << B);
        end else begin
          rem[i+1] <= rem[i];
          rt[i+1]  <= rt[i];
        end
      end
    end
  end

  assign root = rt[32];

endmodule

// ===== src/rmj_div.sv =====
// Pipelined restoring divider, one quotient bit per stage (QW stages).
// Quotient must be known to fit QW bits. No dependencies.
`timescale 1ns / 1ps

module rmj_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = DW + QW;

  logic [NW-1:0] rem [QW+1];
  logic [DW-1:0] dd  [QW+1];
  logic [QW-1:0] q   [QW+1];

  assign rem[0] = num;
  assign dd[0]  = den;
  assign q[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;
    logic [CW-1:0] term;
    assign term = CW'(dd[i]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[i+1] <= dd[i];
        if (CW'(rem[i]) >= term) begin
          rem[i+1] <= rem[i] - term[NW-1:0];
          q[i+1]   <= q[i] | (QW'(1) << B);
        end else begin
          rem[i+1] <= rem[i];
          q[i+1]   <= q[i];
        end
      end
    end
  end

  assign quo = q[QW];

endmodule

// ===== src/radar_measurement_jacobian_unit.sv =====
// Radar measurement Jacobian unit: takes one predicted state word (px, py, vx, vy, signed
// fixed point with FRAC_BITS fraction bits) per cycle and returns the six distinct Jacobian
// entries, saturated to 32 bits, plus a flag when px and py are both zero (entries then 0).
// Throughput is one word per clock while the output is not stalled. The pipeline runs through
// input, multiply and sum registers, the 32-stage square root, the cross-term divider
// (FRAC_BITS + 33 stages), then partial-product, accumulate and output registers. A stall at
// the output freezes the whole pipeline. Uses rmj_pkg, rmj_delay, rmj_sqrt and rmj_div.
`timescale 1ns / 1ps

module radar_measurement_jacobian_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // pos_x, pos_y, vel_x, vel_y
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy,
                                 // drate_dpx, drate_dpy
  output logic [0:0]   m_tuser   // zero_error
);
  import rmj_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 1;       // px/rho magnitude <= 2^F
  localparam int DQW = 2 * F + 1;   // px/s magnitude <= 2^2F
  localparam int TW  = F + 33;      // cross term over s <= 2^(32+F)
  localparam int LD  = TW;          // divider section depth
  localparam int PW  = AW + TW;
  localparam int N   = LD + 38;
  localparam int SBW = 64 + 64 + 32 + 32 + 4;

  logic         en;
  logic [N-1:0] vld;

  assign m_tvalid = vld[N-1];
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[N-2:0], s_tvalid};
  end

  // input register
  logic signed [31:0] px0, py0, vx0, vy0;
  always_ff @(posedge clk) begin
    if (en) begin
      px0 <= s_tdata[31:0];
      py0 <= s_tdata[63:32];
      vx0 <= s_tdata[95:64];
      vy0 <= s_tdata[127:96];
    end
  end

  // multiply stage
  logic [31:0] apx0, apy0;
  assign apx0 = px0[31] ? (~px0 + 32'd1) : px0;
  assign apy0 = py0[31] ? (~py0 + 32'd1) : py0;

  logic [63:0]        sqx1, sqy1;
  logic signed [63:0] c1_1, c2_1;
  logic [31:0]        apx1, apy1;
  logic               pxn1, pyn1, zero1;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx1  <= 64'(apx0) * 64'(apx0);
      sqy1  <= 64'(apy0) * 64'(apy0);
      c1_1  <= 64'(vx0) * 64'(py0);
      c2_1  <= 64'(vy0) * 64'(px0);
      apx1  <= apx0;
      apy1  <= apy0;
      pxn1  <= px0[31];
      pyn1  <= py0[31];
      zero1 <= (px0 == 32'sd0) && (py0 == 32'sd0);
    end
  end

  // sum stage: s and cross term magnitude
  logic signed [64:0] cdiff;
  assign cdiff = 65'(c1_1) - 65'(c2_1);

  logic [63:0] s2, cmag2;
  logic [31:0] apx2, apy2;
  logic        pxn2, pyn2, cneg2, zero2;
  always_ff @(posedge clk) begin
    if (en) begin
      s2    <= sqx1 + sqy1;
      cneg2 <= cdiff[64];
      cmag2 <= cdiff[64] ? 64'(-cdiff) : cdiff[63:0];
      apx2  <= apx1;
      apy2  <= apy1;
      pxn2  <= pxn1;
      pyn2  <= pyn1;
      zero2 <= zero1;
    end
  end

  // square root section
  logic [31:0]    root3;
  logic [SBW-1:0] sb3;
  logic [63:0]    s3, cmag3;
  logic [31:0]    apx3, apy3;
  logic [3:0]     sg3, sg5;

  rmj_sqrt u_sqrt (.clk(clk), .en(en), .x(s2), .root(root3));

  rmj_delay #(.W(SBW), .D(32)) u_sb_sqrt (
    .clk(clk), .en(en),
    .din({s2, cmag2, apx2, apy2, pxn2, pyn2, cneg2, zero2}),
    .dout(sb3)
  );
  assign {s3, cmag3, apx3, apy3, sg3} = sb3;

  // divider section
  logic [AW-1:0]  qa, qb, a5, b5;
  logic [DQW-1:0] qd2, qd3, d2_5, d3_5;
  logic [TW-1:0]  t5;

  rmj_div #(.NW(32 + F), .DW(32), .QW(AW)) u_div_a (
    .clk(clk), .en(en), .num({apx3, F'(0)}), .den(root3), .quo(qa));
  rmj_div #(.NW(32 + F), .DW(32), .QW(AW)) u_div_b (
    .clk(clk), .en(en), .num({apy3, F'(0)}), .den(root3), .quo(qb));
  rmj_div #(.NW(32 + 2 * F), .DW(64), .QW(DQW)) u_div_d2 (
    .clk(clk), .en(en), .num({apy3, (2 * F)'(0)}), .den(s3), .quo(qd2));
  rmj_div #(.NW(32 + 2 * F), .DW(64), .QW(DQW)) u_div_d3 (
    .clk(clk), .en(en), .num({apx3, (2 * F)'(0)}), .den(s3), .quo(qd3));
  rmj_div #(.NW(64 + F), .DW(64), .QW(TW)) u_div_t (
    .clk(clk), .en(en), .num({cmag3, F'(0)}), .den(s3), .quo(t5));

  rmj_delay #(.W(2 * AW), .D(LD - AW)) u_al_ab (
    .clk(clk), .en(en), .din({qa, qb}), .dout({a5, b5}));
  rmj_delay #(.W(2 * DQW), .D(LD - DQW)) u_al_d (
    .clk(clk), .en(en), .din({qd2, qd3}), .dout({d2_5, d3_5}));
  rmj_delay #(.W(4), .D(LD)) u_al_sg (
    .clk(clk), .en(en), .din(sg3), .dout(sg5));

  // partial products of the range-rate terms
  logic [63:0] d2w, d3w;
  assign d2w = 64'(d2_5);
  assign d3w = 64'(d3_5);

  logic [AW+31:0]     p1lo, p2lo;
  logic [AW+TW-33:0]  p1hi, p2hi;
  logic [MAG_W-1:0]   ma6, mb6, md2_6, md3_6;
  logic [3:0]         sg6;
  always_ff @(posedge clk) begin
    if (en) begin
      p1lo  <= (AW + 32)'(b5) * (AW + 32)'(t5[31:0]);
      p1hi  <= (AW + TW - 32)'(b5) * (AW + TW - 32)'(t5[TW-1:32]);
      p2lo  <= (AW + 32)'(a5) * (AW + 32)'(t5[31:0]);
      p2hi  <= (AW + TW - 32)'(a5) * (AW + TW - 32)'(t5[TW-1:32]);
      ma6   <= MAG_W'(a5);
      mb6   <= MAG_W'(b5);
      md2_6 <= (|d2w[63:32]) ? MAG_CAP : d2w[32:0];
      md3_6 <= (|d3w[63:32]) ? MAG_CAP : d3w[32:0];
      sg6   <= sg5;
    end
  end

  // accumulate and scale
  logic [PW-1:0] prod1, prod2, sh1, sh2;
  assign prod1 = PW'(p1lo) + (PW'(p1hi) << 32);
  assign prod2 = PW'(p2lo) + (PW'(p2hi) << 32);
  assign sh1   = prod1 >> F;
  assign sh2   = prod2 >> F;

  logic [MAG_W-1:0] m1_7, m2_7, ma7, mb7, md2_7, md3_7;
  logic [3:0]       sg7;
  always_ff @(posedge clk) begin
    if (en) begin
      m1_7  <= (|sh1[PW-1:32]) ? MAG_CAP : sh1[32:0];
      m2_7  <= (|sh2[PW-1:32]) ? MAG_CAP : sh2[32:0];
      ma7   <= ma6;
      mb7   <= mb6;
      md2_7 <= md2_6;
      md3_7 <= md3_6;
      sg7   <= sg6;
    end
  end

  // output register
  logic pxn7, pyn7, cneg7, zero7;
  assign {pxn7, pyn7, cneg7, zero7} = sg7;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero7) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {sat32(m2_7, pxn7 == cneg7),
                    sat32(m1_7, pyn7 != cneg7),
                    sat32(md3_7, pxn7),
                    sat32(md2_7, !pyn7),
                    sat32(mb7, pyn7),
                    sat32(ma7, pxn7)};
      end
      m_tuser <= zero7;
    end
  end

  // checks
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word not tracked in the pipeline");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("zero position word has nonzero entries");

  // zero-position words divide by zero and carry junk until the output mux
  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    vld[N-2] && !zero7 |-> ma7 <= (MAG_W'(1) << F) && mb7 <= (MAG_W'(1) << F))
    else $error("position over range exceeds one");

endmodule

// ===== tb/radar_measurement_jacobian_unit_tb.sv =====
// Testbench for radar_measurement_jacobian_unit: drives predicted states with random bursts,
// predicts the Jacobian entries in integer arithmetic and checks every output word.
// Depends on rmj_pkg and the unit's RTL.
`timescale 1ns / 1ps

module radar_measurement_jacobian_unit_tb;
  import rmj_pkg::*;

  localparam int FB = 16;
  localparam int LAT = FB + 71;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] vel_y, vel_x, pos_y, pos_x;
  } state_t;

  typedef struct packed {
    logic        zero_error;
    logic [31:0] drate_dpy, drate_dpx, dbearing_dpy, dbearing_dpx, drange_dpy, drange_dpx;
  } jac_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [127:0] s_tdata = '0;
  logic [191:0] m_tdata;
  logic [0:0] m_tuser;

  radar_measurement_jacobian_unit #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  state_t pending_states[$];
  jac_t   expected_jac[$];
  int     errors = 0;
  longint cycles = 0;
  bit     stim_done = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return res;
  endfunction

  // floor(a * 2^k / d) held to cap
  function automatic logic [63:0] frac_div(input logic [63:0] a, input int k,
                                           input logic [63:0] d, input logic [63:0] cap);
    logic [63:0] q, r;
    q = a / d;
    r = a % d;
    if (q >= cap) return cap;
    for (int i = 0; i < k; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q[0] = 1'b1;
      end
      if (q >= cap) return cap;
    end
    return q;
  endfunction

  function automatic logic [31:0] sign_sat(input logic [63:0] m, input logic neg);
    if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
  endfunction

  function automatic logic [63:0] scale_mul(input logic [63:0] m, input logic [63:0] t);
    if (m != 0 && t > 64'hffff_ffff_ffff_ffff / m) return 64'h1_0000_0000;
    return (m * t) >> FB;
  endfunction

  function automatic jac_t jacobian(input state_t st);
    jac_t j;
    longint px, py, vx, vy, c1, c2;
    logic [63:0] apx, apy, s, r, a, b, t, cm, cap32;
    logic cneg;
    px = longint'($signed(st.pos_x));
    py = longint'($signed(st.pos_y));
    vx = longint'($signed(st.vel_x));
    vy = longint'($signed(st.vel_y));
    j = '0;
    cap32 = 64'h1_0000_0000;
    if (px == 0 && py == 0) begin
      j.zero_error = 1'b1;
      return j;
    end
    apx = px < 0 ? -px : px;
    apy = py < 0 ? -py : py;
    s = apx * apx + apy * apy;
    r = isqrt(s);
    a = frac_div(apx, FB, r, cap32);
    b = frac_div(apy, FB, r, cap32);
    j.drange_dpx = sign_sat(a, px < 0);
    j.drange_dpy = sign_sat(b, py < 0);
    j.dbearing_dpx = sign_sat(frac_div(apy, 2 * FB, s, cap32), py > 0);
    j.dbearing_dpy = sign_sat(frac_div(apx, 2 * FB, s, cap32), px < 0);
    c1 = vx * py;
    c2 = vy * px;
    cneg = c1 < c2;
    cm = cneg ? 64'(c2 - c1) : 64'(c1 - c2);
    t = frac_div(cm, FB, s, 64'd1 << 62);
    j.drate_dpx = sign_sat(scale_mul(b, t), (py < 0) != cneg);
    j.drate_dpy = sign_sat(scale_mul(a, t), (px < 0) == cneg);
    return j;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 ** 20)) - (2 ** 19));
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      4: return 32'(1 << $urandom_range(0, 31)) ^ {32{$urandom_range(0, 1) == 1}};
      default: return 32'($signed($urandom_range(0, 2 ** 26)) - (2 ** 25));
    endcase
  endfunction

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (s_tvalid) expected_jac.push_back(jacobian(state_t'(s_tdata)));
        if (gap_left > 0 || pending_states.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          s_tdata <= pending_states.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stalls on its own on/off pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (stall_phase <= 0) stall_phase <= $urandom_range(1, 30);
      else stall_phase <= stall_phase - 1;
      m_tready <= (stall_phase % 7 < 2 && stall_phase > 15) ? 1'b0 : ($urandom_range(0, 4) != 0);
      if (m_tvalid && m_tready) begin
        jac_t got, want;
        got = {m_tuser, m_tdata};
        if (expected_jac.size() == 0) begin
          report("unexpected word", m_tdata[31:0], 32'd0);
        end else begin
          want = expected_jac.pop_front();
          if (got.drange_dpx !== want.drange_dpx)
            report("drange_dpx", got.drange_dpx, want.drange_dpx);
          if (got.drange_dpy !== want.drange_dpy)
            report("drange_dpy", got.drange_dpy, want.drange_dpy);
          if (got.dbearing_dpx !== want.dbearing_dpx)
            report("dbearing_dpx", got.dbearing_dpx, want.dbearing_dpx);
          if (got.dbearing_dpy !== want.dbearing_dpy)
            report("dbearing_dpy", got.dbearing_dpy, want.dbearing_dpy);
          if (got.drate_dpx !== want.drate_dpx)
            report("drate_dpx", got.drate_dpx, want.drate_dpx);
          if (got.drate_dpy !== want.drate_dpy)
            report("drate_dpy", got.drate_dpy, want.drate_dpy);
          if (got.zero_error !== want.zero_error)
            report("zero_error", 32'(got.zero_error), 32'(want.zero_error));
        end
      end
    end
  end

  task automatic add_state(input logic [31:0] px, py, vx, vy);
    pending_states.push_back({vy, vx, py, px});
  endtask

  initial begin
    // both positions zero, extremes, axes, zero cross term, tiny and huge ranges
    add_state(0, 0, 32'h7fff_ffff, 32'h8000_0000);
    add_state(0, 0, 0, 0);
    add_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_state(32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000);
    add_state(0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    add_state(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    add_state(1, 0, 0, 32'h7fff_ffff);
    add_state(0, 1, 32'h8000_0000, 0);
    add_state(32'hffff_ffff, 0, 0, 32'h8000_0000);
    add_state(0, 32'hffff_ffff, 32'h7fff_ffff, 0);
    add_state(1, 1, 32'h8000_0000, 32'h7fff_ffff);
    add_state(32'hffff_ffff, 1, 32'h7fff_ffff, 32'h7fff_ffff);
    add_state(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_state(32'h0003_0000, 32'h0004_0000, 32'h0002_0000, 32'hffff_0000);
    add_state(32'hfffd_0000, 32'h0004_0000, 32'h0001_8000, 32'h0000_4000);
    add_state(32'h0000_0100, 32'hffff_ff00, 32'h0100_0000, 32'hff00_0000);
    add_state(32'h1234_5678, 32'hedcb_a988, 32'h5555_5555, 32'haaaa_aaaa);
    for (int i = 0; i < 1250; i++) begin
      logic [31:0] px, py, vx, vy;
      px = rand_coord();
      py = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_coord();
      if ($urandom_range(0, 30) == 0) px = 0;
      vx = $urandom_range(0, 1) ? $urandom : rand_coord();
      vy = $urandom_range(0, 1) ? $urandom : rand_coord();
      // occasionally make the cross term vanish
      if ($urandom_range(0, 12) == 0) begin
        vx = px;
        vy = py;
      end
      add_state(px, py, vx, vy);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_states.size() == 0 && !s_tvalid);
    stim_done = 1;
  end

  initial begin
    wait (stim_done && expected_jac.size() == 0);
    repeat (2 * LAT) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
